@@ design/color_correction_matrix_fixed_macros.svh @@
// ---------------------------------------------------------------------------
// Color correction matrix assertion macros
// Shared property forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef COLOR_CORRECTION_MATRIX_FIXED_MACROS_SVH
`define COLOR_CORRECTION_MATRIX_FIXED_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CCM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccm: next-cycle check failed");

`endif

@@ design/ccm_pkg.sv @@
// ---------------------------------------------------------------------------
// Color correction matrix package
// Widths, register indexes and reset values shared by the block's files.
// ---------------------------------------------------------------------------
package ccm_pkg;

   localparam int PIXEL_WIDTH = 16;
   localparam int COEF_WIDTH  = 16;
   localparam int ROW_WIDTH   = 3 * COEF_WIDTH;
   localparam int FRAC_WIDTH  = 4;
   localparam int PROD_WIDTH  = PIXEL_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int LIM_WIDTH   = PIXEL_WIDTH - 1;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [4:0] NARROW_BITS = 5'd8;
   localparam logic [4:0] WIDE_BITS   = 5'd16;

   localparam logic signed [COEF_WIDTH-1:0] NARROW_COEF_MAX = COEF_WIDTH'(127);
   localparam logic signed [COEF_WIDTH-1:0] NARROW_COEF_MIN = -COEF_WIDTH'(128);

   localparam logic [ROW_WIDTH-1:0]  ROW_RED_RESET   = ROW_WIDTH'(48'h0000_0000_0100);
   localparam logic [ROW_WIDTH-1:0]  ROW_GREEN_RESET = ROW_WIDTH'(48'h0000_0100_0000);
   localparam logic [ROW_WIDTH-1:0]  ROW_BLUE_RESET  = ROW_WIDTH'(48'h0100_0000_0000);
   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET      = 4'd8;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ROW_RED    = 3'd0,
      CSR_ROW_GREEN  = 3'd1,
      CSR_ROW_BLUE   = 3'd2,
      CSR_FRAC_BITS  = 3'd3,
      CSR_NARROW     = 3'd4,
      CSR_CORRECT_ON = 3'd5
   } csr_index_type;

endpackage

@@ design/color_correction_matrix_fixed.sv @@
// ---------------------------------------------------------------------------
// Color correction matrix, fixed point
// 3x3 matrix on a signed RGB pixel with rounding, clipping and bypass.
// ---------------------------------------------------------------------------
// Path: an accepted request passes the s1, s2, s3 and output valid registers
//   before rsp_valid rises. Throughput: one request per clock while busy is low.
// Four register stages (coefficient select, multiply, sum and round, shift
//   and clip) each take a new pixel every cycle.
// busy is high during reset and in the cycle after it, then stays low; the
//   receiver cannot stall. Reset loads unity matrix, 8 fraction bits, wide.
module color_correction_matrix_fixed (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    req_in_red,
   input  logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    req_in_green,
   input  logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    req_in_blue,
   output logic                                      rsp_valid,
   output logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    rsp_out_red,
   output logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    rsp_out_green,
   output logic signed [ccm_pkg::PIXEL_WIDTH-1:0]    rsp_out_blue,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ccm_pkg::CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [ccm_pkg::ROW_WIDTH-1:0]             csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [ccm_pkg::ROW_WIDTH-1:0]  row_ff [3];
   logic [ccm_pkg::FRAC_WIDTH-1:0] frac_ff;
   logic                           narrow_ff;
   logic                           correct_on_ff;
   logic                           busy_ff;

   logic accept;
   logic csr_write;

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy_ff;
   assign csr_write = csr_valid & csr_ready;

   // Hold off requests while reset is high and in the cycle after it releases.
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]     <= ccm_pkg::ROW_RED_RESET;
         row_ff[1]     <= ccm_pkg::ROW_GREEN_RESET;
         row_ff[2]     <= ccm_pkg::ROW_BLUE_RESET;
         frac_ff       <= ccm_pkg::FRAC_RESET;
         narrow_ff     <= 1'b0;
         correct_on_ff <= 1'b1;
      end else if (csr_write) begin
         // Indexes past the register list are dropped.
         unique case (csr_index)
            ccm_pkg::CSR_ROW_RED:    row_ff[0]     <= csr_data;
            ccm_pkg::CSR_ROW_GREEN:  row_ff[1]     <= csr_data;
            ccm_pkg::CSR_ROW_BLUE:   row_ff[2]     <= csr_data;
            ccm_pkg::CSR_FRAC_BITS:  frac_ff       <= csr_data[ccm_pkg::FRAC_WIDTH-1:0];
            ccm_pkg::CSR_NARROW:     narrow_ff     <= csr_data[0];
            ccm_pkg::CSR_CORRECT_ON: correct_on_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: capture pixel and effective coefficients
   // ------------------------------------------------------------------
   logic signed [ccm_pkg::COEF_WIDTH-1:0]  coef_in [3][3];
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] pix_in  [3];

   logic                                   s1_valid_ff;
   logic signed [ccm_pkg::COEF_WIDTH-1:0]  s1_coef_ff [3][3];
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] s1_pix_ff  [3];
   logic [ccm_pkg::FRAC_WIDTH-1:0]         s1_frac_ff;
   logic                                   s1_narrow_ff;
   logic                                   s1_bypass_ff;

   assign pix_in[0] = req_in_red;
   assign pix_in[1] = req_in_green;
   assign pix_in[2] = req_in_blue;

   // Saturate each coefficient to 8 bits in narrow mode.
   always_comb begin
      logic signed [ccm_pkg::COEF_WIDTH-1:0] c;
      for (int o = 0; o < 3; o++) begin
         for (int i = 0; i < 3; i++) begin
            c = $signed(row_ff[o][ccm_pkg::COEF_WIDTH*i +: ccm_pkg::COEF_WIDTH]);
            if (narrow_ff && (c > ccm_pkg::NARROW_COEF_MAX)) begin
               coef_in[o][i] = ccm_pkg::NARROW_COEF_MAX;
            end else if (narrow_ff && (c < ccm_pkg::NARROW_COEF_MIN)) begin
               coef_in[o][i] = ccm_pkg::NARROW_COEF_MIN;
            end else begin
               coef_in[o][i] = c;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_coef_ff   <= coef_in;
      s1_pix_ff    <= pix_in;
      s1_frac_ff   <= frac_ff;
      s1_narrow_ff <= narrow_ff;
      s1_bypass_ff <= ~correct_on_ff;
   end

   // ------------------------------------------------------------------
   // Stage 2: nine products
   // ------------------------------------------------------------------
   logic                                   s2_valid_ff;
   logic signed [ccm_pkg::PROD_WIDTH-1:0]  s2_prod_ff [3][3];
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] s2_pix_ff  [3];
   logic [ccm_pkg::FRAC_WIDTH-1:0]         s2_frac_ff;
   logic                                   s2_narrow_ff;
   logic                                   s2_bypass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int o = 0; o < 3; o++) begin
         for (int i = 0; i < 3; i++) begin
            s2_prod_ff[o][i] <= s1_coef_ff[o][i] * s1_pix_ff[i];
         end
      end
      s2_pix_ff    <= s1_pix_ff;
      s2_frac_ff   <= s1_frac_ff;
      s2_narrow_ff <= s1_narrow_ff;
      s2_bypass_ff <= s1_bypass_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: dot product plus half an LSB; clip limit from the mode
   // ------------------------------------------------------------------
   logic [ccm_pkg::SUM_WIDTH-1:0] round_add;
   logic [4:0]                    clip_bits;
   logic [ccm_pkg::LIM_WIDTH+1:0] lim_full;
   logic [ccm_pkg::LIM_WIDTH-1:0] lim_in;

   logic                                   s3_valid_ff;
   logic signed [ccm_pkg::SUM_WIDTH-1:0]   s3_sum_ff [3];
   logic [ccm_pkg::LIM_WIDTH-1:0]          s3_lim_ff;
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] s3_pix_ff [3];
   logic [ccm_pkg::FRAC_WIDTH-1:0]         s3_frac_ff;
   logic                                   s3_bypass_ff;

   always_comb begin
      round_add = '0;
      if (s2_frac_ff != '0) begin
         round_add = ccm_pkg::SUM_WIDTH'(1) << (s2_frac_ff - 4'd1);
      end
   end

   // Limit is 2^(W-f)-1, zero when W <= f, capped at the largest pixel.
   always_comb begin
      clip_bits = s2_narrow_ff ? ccm_pkg::NARROW_BITS : ccm_pkg::WIDE_BITS;
      lim_full  = '0;
      if (clip_bits > 5'(s2_frac_ff)) begin
         lim_full = ((ccm_pkg::LIM_WIDTH+2)'(1) << (clip_bits - 5'(s2_frac_ff)))
                    - (ccm_pkg::LIM_WIDTH+2)'(1);
      end
      if (lim_full > (ccm_pkg::LIM_WIDTH+2)'({ccm_pkg::LIM_WIDTH{1'b1}})) begin
         lim_in = {ccm_pkg::LIM_WIDTH{1'b1}};
      end else begin
         lim_in = lim_full[ccm_pkg::LIM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int o = 0; o < 3; o++) begin
         s3_sum_ff[o] <= ccm_pkg::SUM_WIDTH'(s2_prod_ff[o][0])
                       + ccm_pkg::SUM_WIDTH'(s2_prod_ff[o][1])
                       + ccm_pkg::SUM_WIDTH'(s2_prod_ff[o][2])
                       + $signed(round_add);
      end
      s3_lim_ff    <= lim_in;
      s3_pix_ff    <= s2_pix_ff;
      s3_frac_ff   <= s2_frac_ff;
      s3_bypass_ff <= s2_bypass_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: floor shift, symmetric clip, bypass select
   // ------------------------------------------------------------------
   logic signed [ccm_pkg::SUM_WIDTH-1:0]   lim_pos;
   logic signed [ccm_pkg::SUM_WIDTH-1:0]   lim_neg;
   logic signed [ccm_pkg::SUM_WIDTH-1:0]   shifted [3];
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] result_in [3];

   logic                                   out_valid_ff;
   logic signed [ccm_pkg::PIXEL_WIDTH-1:0] out_pix_ff [3];

   assign lim_pos = $signed({{(ccm_pkg::SUM_WIDTH-ccm_pkg::LIM_WIDTH){1'b0}}, s3_lim_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      for (int o = 0; o < 3; o++) begin
         shifted[o] = s3_sum_ff[o] >>> s3_frac_ff;
         if (s3_bypass_ff) begin
            result_in[o] = s3_pix_ff[o];
         end else if (shifted[o] > lim_pos) begin
            result_in[o] = lim_pos[ccm_pkg::PIXEL_WIDTH-1:0];
         end else if (shifted[o] < lim_neg) begin
            result_in[o] = lim_neg[ccm_pkg::PIXEL_WIDTH-1:0];
         end else begin
            result_in[o] = shifted[o][ccm_pkg::PIXEL_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff <= result_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_pix_ff[0];
   assign rsp_out_green = out_pix_ff[1];
   assign rsp_out_blue  = out_pix_ff[2];

endmodule

@@ design/ccm_checker.sv @@
// ---------------------------------------------------------------------------
// Color correction matrix port checker
// Watches request, response and reset timing on the top-level ports.
// ---------------------------------------------------------------------------
`include "color_correction_matrix_fixed_macros.svh"

module ccm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   logic accept;
   assign accept = start & ~busy;

   // Every accepted request raises rsp_valid once it has passed the pipeline registers.
   `CCM_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, ##3 rsp_valid)

   // No response without an accepted request that has passed the pipeline registers.
   `CCM_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, 4))

   // When reset was low in the previous cycle, the block takes requests.
   `CCM_ASSERT_SAME(a_ready_after_reset, clock, reset, $past(!reset), !busy)

endmodule

bind color_correction_matrix_fixed ccm_checker u_ccm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
